// ===== hw/rtl/afm_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afm_pkg
// Widths and constants shared by the audio frame level meter.
// ============================================================================
package afm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PEAK_W      = 16;
    localparam int SQ_W        = 2 * PEAK_W;
    localparam int ENERGY_W    = 43;
    localparam int CNT_W       = 13;
    localparam int RMS_W       = 16;
    localparam int MAX_SAMPLES = 4096;

    // root unit: divide {0,energy} by count, then integer square root
    localparam int RAD_W      = ENERGY_W + 1;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int SUB_W      = REM_W + 2;
    localparam int DIV_STEPS  = RAD_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [PEAK_W-1:0]   peak_t;
    typedef logic [ENERGY_W-1:0] energy_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [RMS_W-1:0]    rms_t;

endpackage

// ===== hw/rtl/afm_root_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afm_root_unit
// Iterative floor(sqrt(floor(dividend / divisor))). One shared subtractor does
// a restoring divide (one quotient bit per cycle), then a digit-by-digit
// square root (one root bit per cycle). done pulses when root is valid; root
// holds until the next start.
// ============================================================================
module afm_root_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  afm_pkg::energy_t dividend,
    input  afm_pkg::count_t  divisor,
    output logic             done,
    output afm_pkg::rms_t    root
);
    import afm_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_DIV  = 3'b010,
        U_SQRT = 3'b100
    } uphase_t;

    uphase_t                 phase_reg, phase_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [RAD_W-1:0]        num_reg, num_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic                    done_reg, done_next;

    logic [SUB_W-1:0]        sub_a, sub_b;
    logic [SUB_W:0]          sub_diff;
    logic                    sub_ge;

    // shared subtractor
    always_comb
    begin
        if (phase_reg == U_DIV)
        begin
            sub_a = SUB_W'({rem_reg[CNT_W-1:0], num_reg[RAD_W-1]});
            sub_b = SUB_W'(divisor);
        end
        else
        begin
            sub_a = {rem_reg, num_reg[RAD_W-1 -: 2]};
            sub_b = SUB_W'({root_reg, 2'b01});
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = ~sub_diff[SUB_W];
    end

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        unique case (phase_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    num_next   = {1'b0, dividend};
                    rem_next   = '0;
                    root_next  = '0;
                    step_next  = '0;
                    phase_next = U_DIV;
                end
            end
            U_DIV:
            begin
                num_next = {num_reg[RAD_W-2:0], sub_ge};
                rem_next = REM_W'(sub_ge ? sub_diff[CNT_W-1:0] : sub_a[CNT_W-1:0]);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    phase_next = U_SQRT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            U_SQRT:
            begin
                num_next  = {num_reg[RAD_W-3:0], 2'b00};
                rem_next  = sub_ge ? sub_diff[REM_W-1:0] : sub_a[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sub_ge};
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    done_next  = 1'b1;
                    phase_next = U_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                phase_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= U_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg[RMS_W-1:0];

endmodule

// ===== hw/rtl/audio_frame_level_meter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// audio_frame_level_meter
// Per-frame peak, energy, sample count and rms of a Q1.15 sample stream.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready): one request per sample, with
//   last_sample set on the final sample of a frame. Output channel
//   (out_valid/out_ready): one request per frame, sent after the last sample.
//   For each sample, the accept cycle squares it and the next cycle updates
//   peak, energy and count. in_ready is low in that accumulate cycle.
//   After a last sample the accumulate cycle also starts the root unit, which
//   runs 44 divide steps and then 22 square-root steps; the meter then waits
//   for done and loads the output register. in_ready stays low from the last
//   sample until the result is loaded into the output register.
//   The output register holds a result while the receiver stalls; sample
//   requests keep flowing meanwhile. A new frame result that is ready while
//   the previous one still waits holds in_ready low until the old one goes.
//   Samples past 4096 in a frame are dropped and set overflow.
//   Reset clears all accumulators and drops any pending result.
// ============================================================================
module audio_frame_level_meter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  afm_pkg::sample_t sample,
    input  logic             last_sample,
    output logic             out_valid,
    input  logic             out_ready,
    output afm_pkg::peak_t   peak_level,
    output afm_pkg::energy_t frame_energy,
    output afm_pkg::rms_t    rms_level,
    output afm_pkg::count_t  sample_count,
    output logic             overflow
);
    import afm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ACCUM = 4'b0010,
        S_CALC  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    peak_t             mag_reg, mag_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic              last_reg, last_next;

    peak_t             peak_reg, peak_next;
    energy_t           energy_reg, energy_next;
    count_t            count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic              out_valid_reg, out_valid_next;
    peak_t             out_peak_reg, out_peak_next;
    energy_t           out_energy_reg, out_energy_next;
    rms_t              out_rms_reg, out_rms_next;
    count_t            out_count_reg, out_count_next;
    logic              out_ovf_reg, out_ovf_next;

    peak_t             mag;
    logic [ENERGY_W:0] energy_sum;
    logic              take;
    logic              unit_start;
    logic              unit_done;
    rms_t              unit_root;
    logic              in_fire;

    // root unit latches the energy total that includes the last sample; the count is read directly while it runs
    afm_root_unit u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (unit_start),
        .dividend (energy_next),
        .divisor  (count_next),
        .done     (unit_done),
        .root     (unit_root)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign mag        = sample[SAMPLE_W-1] ? PEAK_W'(~sample + 1'b1) : PEAK_W'(sample);
    assign take       = (count_reg < CNT_W'(MAX_SAMPLES));
    assign energy_sum = {1'b0, energy_reg} + (ENERGY_W + 1)'(sq_reg);
    assign unit_start = (state_reg == S_ACCUM) && last_reg;

    always_comb
    begin
        state_next      = state_reg;
        mag_next        = mag_reg;
        sq_next         = sq_reg;
        last_next       = last_reg;
        peak_next       = peak_reg;
        energy_next     = energy_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_peak_next   = out_peak_reg;
        out_energy_next = out_energy_reg;
        out_rms_next    = out_rms_reg;
        out_count_next  = out_count_reg;
        out_ovf_next    = out_ovf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mag_next   = mag;
                    sq_next    = mag * mag;
                    last_next  = last_sample;
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                if (take)
                begin
                    if (mag_reg > peak_reg)
                    begin
                        peak_next = mag_reg;
                    end
                    energy_next = energy_sum[ENERGY_W] ? ENERGY_MAX
                                                       : energy_sum[ENERGY_W-1:0];
                    count_next  = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = last_reg ? S_CALC : S_IDLE;
            end
            S_CALC:
            begin
                if (unit_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_peak_next   = peak_reg;
                    out_energy_next = energy_reg;
                    out_rms_next    = (count_reg == '0) ? '0 : unit_root;
                    out_count_next  = count_reg;
                    out_ovf_next    = ovf_reg;
                    peak_next       = '0;
                    energy_next     = '0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            peak_reg      <= '0;
            energy_reg    <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            energy_reg    <= energy_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg        <= mag_next;
        sq_reg         <= sq_next;
        last_reg       <= last_next;
        out_peak_reg   <= out_peak_next;
        out_energy_reg <= out_energy_next;
        out_rms_reg    <= out_rms_next;
        out_count_reg  <= out_count_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign peak_level   = out_peak_reg;
    assign frame_energy = out_energy_reg;
    assign rms_level    = out_rms_reg;
    assign sample_count = out_count_reg;
    assign overflow     = out_ovf_reg;

endmodule

// ===== hw/rtl/afm_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afm_checker
// Port-level checks for the audio frame level meter, bound to the top level.
// ============================================================================
module afm_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             out_valid,
    input  logic             out_ready,
    input  afm_pkg::peak_t   peak_level,
    input  afm_pkg::rms_t    rms_level,
    input  afm_pkg::count_t  sample_count
);
    import afm_pkg::*;

    // result request holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before accept");

    // each sample needs an accumulate cycle
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted in accumulate cycle");

    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_count != '0)
        else $error("frame result with zero count");

    a_rms_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rms_level <= peak_level)
        else $error("rms above peak");

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_level <= PEAK_W'(16'h8000))
        else $error("peak above full scale");

endmodule

bind audio_frame_level_meter afm_checker u_afm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .peak_level   (peak_level),
    .rms_level    (rms_level),
    .sample_count (sample_count)
);

// ===== tb/afm_level_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// afm_level_checker
// Watches the sample and frame-result channels of the audio frame level
// meter. It keeps its own peak, energy, count and overflow accumulators and
// queues the expected frame result on every last sample. It then compares
// each result request field by field with the oldest queued frame.
// ============================================================================
module afm_level_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  afm_pkg::sample_t sample,
    input  logic             last_sample,
    input  logic             out_valid,
    input  logic             out_ready,
    input  afm_pkg::peak_t   peak_level,
    input  afm_pkg::energy_t frame_energy,
    input  afm_pkg::rms_t    rms_level,
    input  afm_pkg::count_t  sample_count,
    input  logic             overflow,
    output int               errors,
    output int               frames_due
);
    import afm_pkg::*;

    typedef struct packed {
        peak_t   peak;
        energy_t energy;
        rms_t    rms;
        count_t  count;
        logic    ovf;
    } frame_levels_t;

    frame_levels_t levels_due[$];
    peak_t         acc_peak;
    energy_t       acc_energy;
    int            acc_count;
    logic          acc_overflow;
    int            mismatches = 0;

    assign errors = mismatches;

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v)
                root = trial;
        end
        return root;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] level check: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int            v;
        int            mag;
        logic [63:0]   total;
        frame_levels_t want;
        if (!rst_n)
        begin
            acc_peak     = '0;
            acc_energy   = '0;
            acc_count    = 0;
            acc_overflow = 1'b0;
            levels_due.delete();
            frames_due <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                v   = int'($signed(sample));
                mag = (v < 0) ? -v : v;
                if (acc_count < MAX_SAMPLES)
                begin
                    if (mag > int'(acc_peak))
                        acc_peak = peak_t'(mag);
                    total = {21'd0, acc_energy} + 64'(longint'(mag) * longint'(mag));
                    acc_energy = (total > 64'(ENERGY_MAX)) ? ENERGY_MAX : total[ENERGY_W-1:0];
                    acc_count++;
                end
                else
                    acc_overflow = 1'b1;
                if (last_sample)
                begin
                    want.peak   = acc_peak;
                    want.energy = acc_energy;
                    want.rms    = (acc_count != 0) ?
                                  rms_t'(floor_root({21'd0, acc_energy} / 64'(acc_count))) : '0;
                    want.count  = count_t'(acc_count);
                    want.ovf    = acc_overflow;
                    levels_due.push_back(want);
                    acc_peak     = '0;
                    acc_energy   = '0;
                    acc_count    = 0;
                    acc_overflow = 1'b0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (levels_due.size() == 0)
                    report_mismatch("frame result with no frame pending");
                else
                begin
                    want = levels_due.pop_front();
                    check_field("peak_level", peak_level, want.peak);
                    check_field("frame_energy", frame_energy, want.energy);
                    check_field("rms_level", rms_level, want.rms);
                    check_field("sample_count", sample_count, want.count);
                    check_field("overflow", overflow, want.ovf);
                end
            end
            frames_due <= levels_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Regression bench for the audio frame level meter. Sends directed frames
// (full-scale extremes, single-sample frames, a full-length frame at negative
// full scale that runs over), then random frames, with random idling on both
// sides. Checking is done by afm_level_checker; this module gives the verdict.
// ============================================================================
module tb_top;
    import afm_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_CYCLES  = 150;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        last_sample = 1'b0;
    logic        out_ready   = 1'b0;
    sample_t     sample      = '0;
    logic        in_ready;
    logic        out_valid;
    peak_t       peak_level;
    energy_t     frame_energy;
    rms_t        rms_level;
    count_t      sample_count;
    logic        overflow;
    int          errors;
    int          frames_due;
    int unsigned cycle_cnt    = 0;
    int          stuck_cycles = 0;
    int          random_sent  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    audio_frame_level_meter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .peak_level   (peak_level),
        .frame_energy (frame_energy),
        .rms_level    (rms_level),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    afm_level_checker meter_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .peak_level   (peak_level),
        .frame_energy (frame_energy),
        .rms_level    (rms_level),
        .sample_count (sample_count),
        .overflow     (overflow),
        .errors       (errors),
        .frames_due   (frames_due)
    );

    // windows with no idling on each side
    function automatic logic in_quiet();
        return (cycle_cnt % 6000) >= 4600;
    endfunction

    function automatic logic out_quiet();
        return (cycle_cnt % 7000) >= 5500;
    endfunction

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        out_ready <= out_quiet() || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no request accepted for %0d cycles", $time, STALL_LIMIT);
                $display("audio_frame_level_meter regression: fail");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_sample(input sample_t s, input logic fin);
        while (!in_quiet() && ($urandom_range(0, 99) < 37))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s;
        last_sample <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_run(input int n, input sample_t s, input logic close_frame);
        for (int i = 0; i < n; i++)
            send_sample(s, close_frame && (i == n - 1));
    endtask

    function automatic sample_t pick_sample(input int style);
        int mag;
        case (style)
            1:
            begin
                case ($urandom_range(0, 5))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h8001;
                    3: return 16'h0001;
                    4: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            end
            2: return sample_t'($urandom_range(0, 512) - 256);
            3:
            begin
                mag = $urandom_range(30000, 32768);
                return $urandom_range(0, 1) ? sample_t'(-mag) : sample_t'(mag);
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int len, input int style);
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(style), i == len - 1);
    endtask

    initial
    begin : stimulus
        int roll;
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-sample frames at the extremes, then a five-sample and a three-sample frame
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8001, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'd100, 1'b0);
        send_sample(sample_t'(-200), 1'b0);
        send_sample(16'd300, 1'b1);

        // full-length frame at negative full scale gives the largest energy;
        // the extra samples, the last one included, are dropped
        send_run(MAX_SAMPLES, 16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0003, 1'b1);

        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                len = $urandom_range(1, 24);
            else if (roll < 96)
                len = $urandom_range(25, 200);
            else
                len = $urandom_range(201, 600);
            send_frame(len, $urandom_range(0, 3));
            random_sent += len;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("audio_frame_level_meter regression: pass");
        else
            $display("audio_frame_level_meter regression: fail");
        $finish;
    end

endmodule
